/* hw/rtl/kuz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kuznyechik package
// Payload types, cipher constants and the byte-level round functions.
// ----------------------------------------------------------------------------
package kuz_pkg;

  localparam int RoundKeys  = 10;
  localparam int StoreWords = 2 * RoundKeys;
  localparam int KsSteps    = 32;
  localparam int CfgRegs    = 4;

  localparam logic [1:0] CFG_KEY_WORD_0 = 2'd0;
  localparam logic [1:0] CFG_KEY_WORD_1 = 2'd1;
  localparam logic [1:0] CFG_KEY_WORD_2 = 2'd2;
  localparam logic [1:0] CFG_KEY_WORD_3 = 2'd3;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  // Round key store write request from the key schedule.
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [63:0] data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] LCOEF [15] = '{
    8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94
  };

  // Multiplication by a constant in GF(2^8) modulo x^8+x^7+x^6+x+1.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
    end
    return r;
  endfunction

  // One step of the LFSR-style linear map R. Byte 0 sits in bits 127:120.
  function automatic logic [127:0] r_step(input logic [127:0] s);
    logic [7:0] acc;
    acc = s[7:0];
    for (int i = 0; i < 15; i++) begin
      acc = acc ^ gf_mul(s[127-8*i -: 8], LCOEF[i]);
    end
    return {acc, s[127:8]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[s[8*i +: 8]];
    return r;
  endfunction

endpackage

/* hw/rtl/kuznyechik_block_encrypt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kuznyechik block encryption engine
// Each item runs nine rounds (two store reads, key add, L layer), then a final key
// addition; no new item is taken until the previous ciphertext has been accepted.
// After a key write the next item first runs the key schedule; rst clears control.
// ----------------------------------------------------------------------------
module kuznyechik_block_encrypt import kuz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_KS_C  = 4'd1;
  localparam logic [3:0] ST_KS_CW = 4'd2;
  localparam logic [3:0] ST_KS_X  = 4'd3;
  localparam logic [3:0] ST_KS_XW = 4'd4;
  localparam logic [3:0] ST_KS_WR = 4'd5;
  localparam logic [3:0] ST_RD0   = 4'd6;
  localparam logic [3:0] ST_RD1   = 4'd7;
  localparam logic [3:0] ST_ADD   = 4'd8;
  localparam logic [3:0] ST_LW    = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]   state;
  logic [63:0]  key_word [CfgRegs];
  logic         keys_expanded;
  logic [127:0] s, ka, kb, kc;
  logic [5:0]   step;
  logic [3:0]   rnd;
  logic [1:0]   wcnt;
  logic [63:0]  hi_word;

  logic         lin_start, lin_done;
  logic [127:0] lin_din, lin_dout;
  rk_wr_t       wr;
  logic [4:0]   rd_addr;
  logic [63:0]  rd_data;

  kuz_lin u_lin (
    .clk(clk), .rst(rst), .start(lin_start), .din(lin_din),
    .done(lin_done), .dout(lin_dout)
  );

  kuz_key_ram u_ram (
    .clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign rd_addr   = {rnd, (state == ST_RD1)};

  always_comb begin
    lin_start = 1'b0;
    lin_din   = kc;
    if (state == ST_KS_C) begin
      lin_start = 1'b1;
      lin_din   = {120'd0, 2'b00, step};
    end else if (state == ST_KS_X) begin
      lin_start = 1'b1;
      lin_din   = sub_bytes(kc ^ ka);
    end else if (state == ST_ADD && rnd != 4'(RoundKeys - 1)) begin
      lin_start = 1'b1;
      lin_din   = sub_bytes(s ^ {hi_word, rd_data});
    end
  end

  // The master key occupies store words 0..3; later pairs come from the schedule.
  always_comb begin
    wr = '0;
    if (state == ST_KS_WR) begin
      wr.en   = 1'b1;
      wr.addr = {step[5:3], wcnt};
      if (step == 6'd0) wr.addr = {3'd0, wcnt};
      unique case (wcnt)
        2'd0:    wr.data = ka[127:64];
        2'd1:    wr.data = ka[63:0];
        2'd2:    wr.data = kb[127:64];
        default: wr.data = kb[63:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      keys_expanded <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < CfgRegs; i++) key_word[i] <= '0;
    end else begin
      if (cfg_we) begin
        key_word[cfg_index] <= cfg_wdata;
        keys_expanded       <= 1'b0;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            s   <= {in_data.block_high, in_data.block_low};
            rnd <= '0;
            if (keys_expanded) begin
              state <= ST_RD0;
            end else begin
              ka    <= {key_word[0], key_word[1]};
              kb    <= {key_word[2], key_word[3]};
              step  <= '0;
              wcnt  <= '0;
              state <= ST_KS_WR;
            end
          end
        end
        ST_KS_WR: begin
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd3) begin
            if (step == 6'(KsSteps)) begin
              keys_expanded <= 1'b1;
              state         <= ST_RD0;
            end else begin
              step  <= step + 6'd1;
              state <= ST_KS_C;
            end
          end
        end
        ST_KS_C:  state <= ST_KS_CW;
        ST_KS_CW: if (lin_done) begin
          kc    <= lin_dout;
          state <= ST_KS_X;
        end
        ST_KS_X:  state <= ST_KS_XW;
        ST_KS_XW: if (lin_done) begin
          ka <= lin_dout ^ kb;
          kb <= ka;
          if (step[2:0] == 3'd0) begin
            wcnt  <= '0;
            state <= ST_KS_WR;
          end else begin
            step  <= step + 6'd1;
            state <= ST_KS_C;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (rnd == 4'(RoundKeys - 1)) begin
            out_data  <= s ^ {hi_word, rd_data};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            state <= ST_LW;
          end
        end
        ST_LW: if (lin_done) begin
          s     <= lin_dout;
          rnd   <= rnd + 4'd1;
          state <= ST_RD0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // High key word arrives in the cycle before the low word.
  always_ff @(posedge clk) begin
    if (state == ST_RD1) hi_word <= rd_data;
  end

endmodule

/* hw/rtl/kuz_lin.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kuznyechik linear layer
// Applies L as sixteen R steps, four per cycle.
// ----------------------------------------------------------------------------
module kuz_lin import kuz_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] din,
  output logic         done,
  output logic [127:0] dout
);

  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic [127:0] step4;

  always_comb begin
    step4 = r_step(r_step(r_step(r_step(start ? din : acc))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd1;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start || busy) acc <= step4;
  end

  assign dout = acc;

endmodule

/* hw/rtl/kuz_key_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kuznyechik round key store
// Twenty 64-bit words, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kuz_key_ram import kuz_pkg::*; (
  input  logic        clk,
  input  rk_wr_t      wr,
  input  logic [4:0]  rd_addr,
  output logic [63:0] rd_data
);

  logic [63:0] mem [StoreWords];

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kuznyechik block encryption testbench
// Drives plaintext blocks and key writes into the encryption engine. A local
// cipher predictor expands the key and encrypts each block. Every ciphertext
// is compared against it, under several key settings and idle patterns.
// ----------------------------------------------------------------------------
module tb import kuz_pkg::*; ();

  localparam int LimitCycles = 3000000;
  localparam int DrainCycles = 500;

  typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  index;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          typed;
    out_item_t   cipher;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_KEY_WORD_0;
  logic [63:0] cfg_wdata = '0;

  // Predictor state.
  logic [63:0]  master_key [4];
  logic [127:0] round_key [RoundKeys];
  bit           schedule_done;

  out_item_t cipher_expected_q[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;
  bit        hold_request = 1'b0;
  int        hold_left = 0;

  kuznyechik_block_encrypt i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] prod;
    prod = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
    end
    return prod;
  endfunction

  // Sixteen shifts of the byte register, each feeding back the weighted sum.
  function automatic logic [127:0] linear_mix(logic [127:0] s);
    logic [7:0] acc;
    for (int n = 0; n < 16; n++) begin
      acc = s[7:0];
      for (int i = 0; i < 15; i++) acc ^= field_mul(s[127-8*i -: 8], LCOEF[i]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function automatic logic [127:0] substitute(logic [127:0] s);
    for (int i = 0; i < 16; i++) s[8*i +: 8] = SBOX[s[8*i +: 8]];
    return s;
  endfunction

  function automatic void expand_round_keys();
    logic [127:0] a, b, c;
    a = {master_key[0], master_key[1]};
    b = {master_key[2], master_key[3]};
    round_key[0] = a;
    round_key[1] = b;
    for (int step = 1; step <= KsSteps; step++) begin
      c = linear_mix(128'(step));
      c = linear_mix(substitute(c ^ a)) ^ b;
      b = a;
      a = c;
      if (step % 8 == 0) begin
        round_key[step / 4] = a;
        round_key[step / 4 + 1] = b;
      end
    end
    schedule_done = 1'b1;
  endfunction

  function automatic out_item_t encrypt_block(in_item_t blk);
    logic [127:0] s;
    if (!schedule_done) expand_round_keys();
    s = {blk.block_high, blk.block_low};
    for (int r = 0; r < RoundKeys; r++) begin
      s ^= round_key[r];
      if (r < RoundKeys - 1) s = linear_mix(substitute(s));
    end
    return '{cipher_high: s[127:64], cipher_low: s[63:0]};
  endfunction

  // Key writes only happen with the engine idle.
  task automatic write_key(logic [1:0] index, logic [63:0] value);
    wait (cipher_expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    master_key[index] = value;
    schedule_done = 1'b0;
  endtask

  task automatic send_block(in_item_t blk, bit typed, out_item_t cipher);
    out_item_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predicted = encrypt_block(blk);
    if (typed && predicted !== cipher) begin
      $display("%0t predictor disagrees with known vector: expected %h actual %h",
               $time, cipher, predicted);
      error_count++;
    end
    in_valid <= 1'b1;
    in_data <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_expected_q.push_back(typed ? cipher : predicted);
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver stall, with a long hold-off counted here on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      out_stall <= 1'b1;
      hold_left <= 1500;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_expected_q.size() == 0) begin
        $display("%0t unexpected ciphertext: expected none actual %h", $time, out_data);
        error_count++;
      end else begin
        exp_item = cipher_expected_q.pop_front();
        if (out_data.cipher_high !== exp_item.cipher_high) begin
          $display("%0t cipher_high mismatch: expected %h actual %h",
                   $time, exp_item.cipher_high, out_data.cipher_high);
          error_count++;
        end
        if (out_data.cipher_low !== exp_item.cipher_low) begin
          $display("%0t cipher_low mismatch: expected %h actual %h",
                   $time, exp_item.cipher_low, out_data.cipher_low);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    row_t      rows[$];
    out_item_t none;
    in_item_t  blk;
    int        idle_plan[4][2];
    logic [63:0] std_key[4];
    logic [63:0] fill;

    none = '0;
    std_key = '{64'h8899AABBCCDDEEFF, 64'h0011223344556677,
                64'hFEDCBA9876543210, 64'h0123456789ABCDEF};
    for (int i = 0; i < 4; i++) master_key[i] = '0;
    schedule_done = 1'b0;

    // Blocks before any key write run the schedule on the all-zero key.
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, '0, '0, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, '1, '1, 1'b0, none});
    rows.push_back('{ROW_KEY, CFG_KEY_WORD_0, std_key[0], '0, 1'b0, none});
    rows.push_back('{ROW_KEY, CFG_KEY_WORD_1, std_key[1], '0, 1'b0, none});
    rows.push_back('{ROW_KEY, CFG_KEY_WORD_2, std_key[2], '0, 1'b0, none});
    rows.push_back('{ROW_KEY, CFG_KEY_WORD_3, std_key[3], '0, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, 64'h1122334455667700, 64'hFFEEDDCCBBAA9988,
                     1'b1, '{64'h7F679D90BEBC2430, 64'h5A468D42B9D4EDCD}});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, 64'h8000000000000000, 64'h1, 1'b0, none});
    // Rewriting a key word with its own value forces a new schedule.
    rows.push_back('{ROW_KEY, CFG_KEY_WORD_2, std_key[2], '0, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, 64'h1122334455667700, 64'hFFEEDDCCBBAA9988,
                     1'b1, '{64'h7F679D90BEBC2430, 64'h5A468D42B9D4EDCD}});
    for (int i = 0; i < 4; i++)
      rows.push_back('{ROW_KEY, 2'(i), '1, '0, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, '0, '0, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, '1, '1, 1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
                     1'b0, none});
    rows.push_back('{ROW_BLOCK, CFG_KEY_WORD_0, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA,
                     1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_KEY) begin
        in_valid <= 1'b0;
        write_key(rows[i].index, rows[i].hi);
      end else begin
        blk = '{block_high: rows[i].hi, block_low: rows[i].lo};
        send_block(blk, rows[i].typed, rows[i].cipher);
      end
    end

    idle_plan = '{'{0, 0}, '{53, 0}, '{0, 53}, '{18, 18}};
    for (int p = 0; p < 8; p++) begin
      in_valid <= 1'b0;
      // New key between phases: extremes first, then random words.
      for (int w = 0; w < 4; w++) begin
        fill = (p == 0) ? '0 : (p == 1) ? '1 : random_word();
        if (p < 2 || $urandom_range(1)) write_key(2'(w), fill);
      end
      sender_idle_pct = idle_plan[p % 4][0];
      receiver_stall_pct = idle_plan[p % 4][1];
      for (int n = 0; n < 166; n++) begin
        if (p == 2 && n == 20) begin
          sender_idle_pct = 0;
          hold_request <= 1'b1;
          @(posedge clk);
          hold_request <= 1'b0;
        end
        if (p == 2 && n == 60) begin
          sender_idle_pct = idle_plan[2][0];
        end
        if (n == 100 && p == 5) begin
          in_valid <= 1'b0;
          wait (cipher_expected_q.size() == 0);
          @(posedge clk);
        end
        blk = '{block_high: random_word(), block_low: random_word()};
        send_block(blk, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    wait (cipher_expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kuz_pkg.sv
hw/rtl/kuz_lin.sv
hw/rtl/kuz_key_ram.sv
hw/rtl/kuznyechik_block_encrypt.sv
tb/sv/tb.sv
